### sv/evq_pkg.sv
// Shared types and constants for the timed event queue.
`timescale 1ns / 1ps
`default_nettype none
package evq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_REM_OWNER  = 3'd1,
    OP_REM_OWN_TY = 3'd2,
    OP_FIND_FIRST = 3'd3,
    OP_FIND_NEXT  = 3'd4,
    OP_POP_DUE    = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] due;
    logic [3:0]  typ;
    logic [15:0] owner;
    logic [15:0] data;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_EV,
    S_HEAD_RD,
    S_HEAD_EV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_ev;
    logic head_rd;
    logic head_cap;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

### sv/evq_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface evq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] now_time;
  logic [31:0] delay;
  logic [15:0] owner;
  logic [3:0]  event_type;
  logic [15:0] data_tag;
  modport source (output valid, op, now_time, delay, owner, event_type, data_tag,
                  input ready);
  modport sink (input valid, op, now_time, delay, owner, event_type, data_tag,
                output ready);
endinterface

interface evq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] ev_time;
  logic [3:0]  ev_type;
  logic [15:0] ev_owner;
  logic [15:0] ev_data;
  logic [6:0]  entry_count;
  logic [31:0] head_time;
  logic        is_empty;
  modport source (output valid, status, ev_time, ev_type, ev_owner, ev_data,
                  entry_count, head_time, is_empty, input ready);
  modport sink (input valid, status, ev_time, ev_type, ev_owner, ev_data,
                entry_count, head_time, is_empty, output ready);
endinterface
`default_nettype wire

### sv/evq_ctrl.sv
// Controller state machine sequencing the table walk.
`timescale 1ns / 1ps
`default_nettype none
module evq_ctrl import evq_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = sts.active ? S_SCAN_RD : S_HEAD_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_next  = sts.last ? S_HEAD_RD : S_SCAN_RD;
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_next  = S_HEAD_EV;
      end
      S_HEAD_EV: begin
        cmd.head_cap = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/evq_datapath.sv
// Event table memory, scan indexes and result registers.
`timescale 1ns / 1ps
`default_nettype none
module evq_datapath import evq_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  wire  [2:0]  op,
  input  wire  [31:0] now_time,
  input  wire  [31:0] delay,
  input  wire  [15:0] owner,
  input  wire  [3:0]  event_type,
  input  wire  [15:0] data_tag,
  output logic [1:0]  status,
  output logic [31:0] ev_time,
  output logic [3:0]  ev_type,
  output logic [15:0] ev_owner,
  output logic [15:0] ev_data,
  output logic [6:0]  entry_count,
  output logic [31:0] head_time,
  output logic        is_empty
);

  entry_t mem [CAPACITY];
  entry_t rdata;

  logic [2:0]  op_r;
  logic [31:0] now_r, due_r;
  logic [15:0] own_r, tag_r;
  logic [3:0]  typ_r;
  logic [CNT_W-1:0] pos, wr, fill, cursor;
  logic cur_valid, active, removed;

  logic [32:0] sum;
  logic [31:0] due_in;
  assign sum    = {1'b0, now_time} + {1'b0, delay};
  assign due_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  // Scan step decode
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic             last, hit, match, keep;
  logic [IDX_W-1:0] raddr;
  logic [CNT_W-1:0] pos_m1, pos_p1;

  assign pos_m1 = pos - CNT_W'(1);
  assign pos_p1 = pos + CNT_W'(1);
  assign match  = (rdata.owner == own_r) &&
                  (op_r == OP_REM_OWNER || rdata.typ == typ_r);

  always_comb begin
    we    = 1'b0;
    waddr = pos[IDX_W-1:0];
    wdata = rdata;
    last  = 1'b1;
    hit   = 1'b0;
    keep  = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (pos != '0 && rdata.due > due_r) begin
          we    = 1'b1;
          last  = 1'b0;
        end else begin
          we    = 1'b1;
          wdata = '{due: due_r, typ: typ_r, owner: own_r, data: tag_r};
        end
      end
      OP_REM_OWNER, OP_REM_OWN_TY, OP_POP_DUE: begin
        hit  = (op_r == OP_POP_DUE) ? (pos == '0) : match;
        keep = !(op_r == OP_POP_DUE && pos == '0 && now_r < rdata.due);
        if (keep && !hit) begin
          we    = 1'b1;
          waddr = wr[IDX_W-1:0];
        end
        last = !keep || (pos_p1 == fill);
      end
      OP_FIND_FIRST, OP_FIND_NEXT: begin
        last = match || (pos_p1 == fill);
      end
      default: last = 1'b1;
    endcase
  end

  assign sts.active = active;
  assign sts.last   = last;

  assign raddr = cmd.head_rd ? '0 :
                 (op_r == OP_INSERT) ? pos_m1[IDX_W-1:0] : pos[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_ev && we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.scan_rd || cmd.head_rd) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      cursor    <= '0;
      cur_valid <= 1'b0;
      active    <= 1'b0;
    end else if (cmd.load) begin
      active <= 1'b0;
      case (op)
        OP_INSERT: begin
          active <= (fill != CNT_W'(CAPACITY));
        end
        OP_REM_OWNER, OP_REM_OWN_TY, OP_POP_DUE: begin
          active <= (fill != '0);
        end
        OP_FIND_FIRST: begin
          active <= (fill != '0);
          if (fill == '0) begin
            cur_valid <= 1'b0;
            cursor    <= '0;
          end
        end
        OP_FIND_NEXT: begin
          if (cur_valid && (cursor + CNT_W'(1)) < fill) begin
            active <= 1'b1;
          end else begin
            cur_valid <= 1'b0;
            cursor    <= '0;
          end
        end
        OP_CLEAR: begin
          fill      <= '0;
          cur_valid <= 1'b0;
          cursor    <= '0;
        end
        default: active <= 1'b0;
      endcase
    end else if (cmd.scan_ev && last) begin
      case (op_r)
        OP_INSERT: begin
          fill      <= fill + CNT_W'(1);
          cur_valid <= 1'b0;
          cursor    <= '0;
        end
        OP_REM_OWNER, OP_REM_OWN_TY, OP_POP_DUE: begin
          if (keep) begin
            fill <= hit ? wr : wr + CNT_W'(1);
            if (hit || removed) begin
              cur_valid <= 1'b0;
              cursor    <= '0;
            end
          end
        end
        OP_FIND_FIRST, OP_FIND_NEXT: begin
          cur_valid <= match;
          cursor    <= match ? pos : '0;
        end
        default: cur_valid <= cur_valid;
      endcase
    end
  end

  // Operand, index and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op;
      now_r    <= now_time;
      due_r    <= due_in;
      own_r    <= owner;
      typ_r    <= event_type;
      tag_r    <= data_tag;
      wr       <= '0;
      removed  <= 1'b0;
      pos      <= '0;
      status   <= ST_OK;
      ev_time  <= '0;
      ev_type  <= '0;
      ev_owner <= '0;
      ev_data  <= '0;
      case (op)
        OP_INSERT: begin
          pos <= fill;
          if (fill == CNT_W'(CAPACITY)) status <= ST_FULL;
        end
        OP_POP_DUE, OP_FIND_FIRST: begin
          if (fill == '0) status <= ST_NONE;
        end
        OP_FIND_NEXT: begin
          pos <= cursor + CNT_W'(1);
          if (!(cur_valid && (cursor + CNT_W'(1)) < fill)) status <= ST_NONE;
        end
        default: pos <= '0;
      endcase
    end else if (cmd.scan_ev) begin
      case (op_r)
        OP_INSERT: pos <= pos_m1;
        OP_REM_OWNER, OP_REM_OWN_TY, OP_POP_DUE: begin
          pos <= pos_p1;
          if (!keep) begin
            status <= ST_NONE;
          end else if (hit) begin
            removed <= 1'b1;
            if (op_r == OP_POP_DUE) begin
              ev_time  <= rdata.due;
              ev_type  <= rdata.typ;
              ev_owner <= rdata.owner;
              ev_data  <= rdata.data;
            end
          end else begin
            wr <= wr + CNT_W'(1);
          end
        end
        OP_FIND_FIRST, OP_FIND_NEXT: begin
          pos <= pos_p1;
          if (match) begin
            ev_time  <= rdata.due;
            ev_type  <= rdata.typ;
            ev_owner <= rdata.owner;
            ev_data  <= rdata.data;
          end else if (last) begin
            status <= ST_NONE;
          end
        end
        default: pos <= pos;
      endcase
    end
    if (cmd.head_cap) begin
      head_time <= (fill != '0) ? rdata.due : 32'd0;
    end
  end

  assign entry_count = 7'(fill);
  assign is_empty    = (fill == '0);

endmodule
`default_nettype wire

### sv/timed_event_queue_unit.sv
// Top level of the timed event queue: controller plus table datapath.
// Usage:
//   in_ch carries one request transaction (op, now_time, delay, owner,
//   event_type, data_tag); out_ch returns exactly one result transaction
//   per request (status, event fields, entry_count, head_time, is_empty).
//   The table holds up to CAPACITY events sorted by due time in a
//   single-port style memory: one write and one registered read per cycle.
// Sequencing: one request at a time. Each table entry visited takes a
//   memory read, then an evaluate and write-back step. Insert walks from
//   the tail down to the insertion point, removals walk the whole table
//   compacting it, pop does too unless the head is not yet due, finds
//   stop at the first match. Dispatch comes before the walk and a head
//   read after it; requests with nothing to visit skip the walk.
// Reset: rst (synchronous) empties the table and drops the search cursor;
//   memory contents are not cleared since only entries below the fill
//   count are ever used.
// Stall: the result is held in registers with out_ch.valid high until the
//   receiver takes it; in_ch.ready stays low until then.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_queue_unit import evq_pkg::*; (
  input wire clk,
  input wire rst,
  evq_in_if.sink    in_ch,
  evq_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the walk
  evq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the table and build the result
  evq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (in_ch.op),
    .now_time    (in_ch.now_time),
    .delay       (in_ch.delay),
    .owner       (in_ch.owner),
    .event_type  (in_ch.event_type),
    .data_tag    (in_ch.data_tag),
    .status      (out_ch.status),
    .ev_time     (out_ch.ev_time),
    .ev_type     (out_ch.ev_type),
    .ev_owner    (out_ch.ev_owner),
    .ev_data     (out_ch.ev_data),
    .entry_count (out_ch.entry_count),
    .head_time   (out_ch.head_time),
    .is_empty    (out_ch.is_empty)
  );

  // A new request is never taken while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("request accepted while a result is pending");

  // Count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.entry_count <= 7'(CAPACITY)))
    else $error("entry count beyond capacity");

  // Empty flag and head time agree with the count
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.is_empty) |-> (out_ch.head_time == 32'd0 &&
      out_ch.entry_count == 7'd0))
    else $error("empty flag inconsistent");

  // Full status only when the table is full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == ST_FULL) |->
      (out_ch.entry_count == 7'(CAPACITY)))
    else $error("full status with room left");

endmodule
`default_nettype wire

### tb/evq_checker.sv
// Checker for the timed event queue: predicts each result and compares it field by field.
`timescale 1ns / 1ps
module evq_checker import evq_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  evq_in_if.sink      in_mon,
  evq_out_if.sink     out_mon,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ev_time;
    logic [3:0]  ev_type;
    logic [15:0] ev_owner;
    logic [15:0] ev_data;
    logic [6:0]  entry_count;
    logic [31:0] head_time;
    logic        is_empty;
  } result_t;

  entry_t    table_q[$];
  logic      cur_ok;
  int        cur_pos;
  result_t   result_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic result_t predict_queue(input logic [2:0] op, input logic [31:0] now_t,
                                            input logic [31:0] dly, input logic [15:0] own,
                                            input logic [3:0] typ, input logic [15:0] tag);
    result_t r;
    entry_t  e;
    logic [32:0] sum;
    int pos;
    int i;
    int start;
    bit found;
    bit removed;
    r = '0;
    found = 0;
    case (op)
      OP_INSERT: begin
        if (table_q.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          sum = {1'b0, now_t} + {1'b0, dly};
          e.due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          e.typ = typ; e.owner = own; e.data = tag;
          pos = 0;
          while (pos < table_q.size() && table_q[pos].due <= e.due) pos++;
          table_q.insert(pos, e);
          cur_ok = 0;
        end
      end
      OP_REM_OWNER, OP_REM_OWN_TY: begin
        removed = 0;
        i = 0;
        while (i < table_q.size()) begin
          if (table_q[i].owner == own && (op == OP_REM_OWNER || table_q[i].typ == typ)) begin
            table_q.delete(i);
            removed = 1;
          end else i++;
        end
        if (removed) cur_ok = 0;
      end
      OP_FIND_FIRST, OP_FIND_NEXT: begin
        start = -1;
        if (op == OP_FIND_FIRST) start = 0;
        else if (cur_ok && cur_pos < table_q.size()) start = cur_pos + 1;
        if (start >= 0)
          for (i = start; i < table_q.size() && !found; i++)
            if (table_q[i].owner == own && table_q[i].typ == typ) begin
              found = 1;
              pos = i;
            end
        if (found) begin
          cur_ok = 1; cur_pos = pos;
          e = table_q[pos];
          r.ev_time = e.due; r.ev_type = e.typ; r.ev_owner = e.owner; r.ev_data = e.data;
        end else begin
          cur_ok = 0;
          r.status = ST_NONE;
        end
      end
      OP_POP_DUE: begin
        if (table_q.size() > 0 && now_t >= table_q[0].due) begin
          e = table_q.pop_front();
          r.ev_time = e.due; r.ev_type = e.typ; r.ev_owner = e.owner; r.ev_data = e.data;
          cur_ok = 0;
        end else r.status = ST_NONE;
      end
      OP_CLEAR: begin
        table_q.delete();
        cur_ok = 0;
      end
      default: ;
    endcase
    r.entry_count = 7'(table_q.size());
    r.head_time = table_q.size() > 0 ? table_q[0].due : 32'd0;
    r.is_empty = table_q.size() == 0;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      table_q.delete();
      result_q.delete();
      cur_ok <= 0;
      cur_pos <= 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      // Take the result before predicting this edge's request: one request at a time.
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = result_q.pop_front();
          if (out_mon.status !== want.status) report("status", out_mon.status, want.status);
          if (out_mon.ev_time !== want.ev_time) report("ev_time", out_mon.ev_time, want.ev_time);
          if (out_mon.ev_type !== want.ev_type) report("ev_type", out_mon.ev_type, want.ev_type);
          if (out_mon.ev_owner !== want.ev_owner)
            report("ev_owner", out_mon.ev_owner, want.ev_owner);
          if (out_mon.ev_data !== want.ev_data) report("ev_data", out_mon.ev_data, want.ev_data);
          if (out_mon.entry_count !== want.entry_count)
            report("entry_count", out_mon.entry_count, want.entry_count);
          if (out_mon.head_time !== want.head_time)
            report("head_time", out_mon.head_time, want.head_time);
          if (out_mon.is_empty !== want.is_empty)
            report("is_empty", out_mon.is_empty, want.is_empty);
        end
      end
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(predict_queue(in_mon.op, in_mon.now_time, in_mon.delay,
                                         in_mon.owner, in_mon.event_type, in_mon.data_tag));
      pending <= result_q.size();
    end
  end

endmodule

### tb/timed_event_queue_unit_test.sv
// Testbench top for the timed event queue: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module timed_event_queue_unit_test;
  import evq_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  evq_in_if  in_ch();
  evq_out_if out_ch();

  timed_event_queue_unit uut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  evq_checker checker_i (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                         .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  // Watchdog: about 2000 items plus heavy stalls fit well inside the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1_500_000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one request and hold it until accepted; insert random sender gaps first.
  // Valid stays high after acceptance so back-to-back requests need no gap; drop it
  // only when idling.
  task automatic send_request(input op_t op, input logic [31:0] now_t, input logic [31:0] dly,
                              input logic [15:0] own, input logic [3:0] typ,
                              input logic [15:0] tag);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) in_ch.valid <= 0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid      <= 1;
    in_ch.op         <= op;
    in_ch.now_time   <= now_t;
    in_ch.delay      <= dly;
    in_ch.owner      <= own;
    in_ch.event_type <= typ;
    in_ch.data_tag   <= tag;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Raw op code seven is not an enum member; drive it directly.
  task automatic send_unused_op();
    in_ch.valid <= 1;
    in_ch.op    <= 3'h7;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Random item biased toward a small owner/type set so finds and removals hit.
  task automatic send_random(input int fill_bias);
    op_t op;
    int  pick;
    logic [31:0] now_t;
    logic [31:0] dly;
    pick = $urandom_range(99);
    if (pick < fill_bias) op = OP_INSERT;
    else if (pick < fill_bias + 8) op = OP_REM_OWNER;
    else if (pick < fill_bias + 14) op = OP_REM_OWN_TY;
    else if (pick < fill_bias + 28) op = OP_FIND_FIRST;
    else if (pick < fill_bias + 48) op = OP_FIND_NEXT;
    else if (pick < 99) op = OP_POP_DUE;
    else op = OP_CLEAR;
    now_t = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2000);
    dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
    send_request(op, now_t, dly,
                 ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3)),
                 ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(1)),
                 16'($urandom));
  endtask

  // Drop valid and hold until the checker has seen every expected result.
  task automatic wait_drained();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    in_ch.valid      = 0;
    in_ch.op         = OP_CLEAR;
    in_ch.now_time   = 0;
    in_ch.delay      = 0;
    in_ch.owner      = 0;
    in_ch.event_type = 0;
    in_ch.data_tag   = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty-table cases, saturation, ordering of equal times, field extremes.
    send_request(OP_POP_DUE, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_request(OP_FIND_NEXT, 0, 0, 0, 0, 0);
    send_request(OP_FIND_FIRST, 0, 0, 0, 0, 0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 16'hFFFF);
    send_request(OP_INSERT, 10, 5, 0, 0, 16'h0001);
    send_request(OP_INSERT, 15, 0, 0, 0, 16'h0002);
    send_request(OP_INSERT, 0, 0, 16'h1234, 4'h5, 16'hABCD);
    send_request(OP_FIND_FIRST, 0, 0, 0, 0, 0);
    send_request(OP_FIND_NEXT, 0, 0, 0, 0, 0);
    send_request(OP_FIND_NEXT, 0, 0, 0, 0, 0);
    send_request(OP_FIND_NEXT, 0, 0, 0, 0, 0);
    send_request(OP_FIND_FIRST, 0, 0, 0, 0, 0);
    send_request(OP_REM_OWNER, 0, 0, 16'h7777, 0, 0);
    send_request(OP_FIND_NEXT, 0, 0, 0, 0, 0);
    send_unused_op();
    send_request(OP_REM_OWN_TY, 0, 0, 16'h1234, 4'h5, 0);
    send_request(OP_POP_DUE, 14, 0, 0, 0, 0);
    send_request(OP_POP_DUE, 15, 0, 0, 0, 0);
    send_request(OP_REM_OWNER, 0, 0, 0, 0, 0);
    // Fill to capacity; the inserts beyond it must report full.
    repeat (CAPACITY + 1) send_request(OP_INSERT, $urandom_range(50), $urandom_range(50),
                                       16'($urandom_range(3)), 4'($urandom_range(1)),
                                       16'($urandom));
    send_request(OP_FIND_FIRST, 0, 0, 3, 1, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 0);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 36 : 0;
      for (int n = 0; n < 500; n++) begin
        send_random((n % 200 < 100) ? 55 : 30);
        // Hold off once per phase until every expected result has come.
        if (n == 250) wait_drained();
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
